// ===== hw/rtl/qapd_pkg.sv =====
// Package for the quaternion attitude PD controller: beat structs, register
// indexes, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package qapd_pkg;

  localparam int CordicSteps = 16;
  localparam int CordicGain = 39797;
  localparam int HalfPiU16 = 102944;
  localparam int PiU16 = 205887;
  localparam int Deg16ToRadQ12 = 292818;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegAttP = 3'd0,
    RegAttD = 3'd1,
    RegYawP = 3'd2,
    RegYawD = 3'd3,
    RegThrScale = 3'd4,
    RegPitchLim = 3'd5,
    RegYawSet = 3'd6,
    RegNone = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] roll_target;
    logic signed [15:0] pitch_target;
    logic signed [15:0] radio_pitch;
    logic [7:0] radio_throttle;
    logic [15:0] position_thrust;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] roll_command;
    logic signed [15:0] pitch_command;
    logic signed [15:0] yaw_command;
    logic [15:0] thrust_command;
  } out_beat_t;

  // CORDIC angle state: x, y in 2^-16, z in 2^-16 rad.
  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic flip;
  } cordic_t;

  function automatic logic signed [19:0] atan_lut(input logic [3:0] idx);
    logic signed [19:0] r;
    unique case (idx)
      4'd0: r = 20'sd51472;
      4'd1: r = 20'sd30385;
      4'd2: r = 20'sd16055;
      4'd3: r = 20'sd8150;
      4'd4: r = 20'sd4091;
      4'd5: r = 20'sd2047;
      4'd6: r = 20'sd1024;
      4'd7: r = 20'sd512;
      4'd8: r = 20'sd256;
      4'd9: r = 20'sd128;
      4'd10: r = 20'sd64;
      4'd11: r = 20'sd32;
      4'd12: r = 20'sd16;
      4'd13: r = 20'sd8;
      4'd14: r = 20'sd4;
      default: r = 20'sd2;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/qapd_cordic.sv =====
// Pipelined CORDIC for sine and cosine of a half angle, one step per stage.
// Depends on qapd_pkg. The input, every step and the output are registered.
`timescale 1ns / 1ps
module qapd_cordic
  import qapd_pkg::*;
(
  input  logic                clk_i,
  input  logic signed [16:0]  angle_i,
  output logic signed [15:0]  cos_o,
  output logic signed [15:0]  sin_o
);

  cordic_t stage_q [CordicSteps+1];
  logic signed [19:0] z0;

  always_comb begin
    z0 = 20'(angle_i) <<< 3;
  end

  always_ff @(posedge clk_i) begin
    stage_q[0].x <= 20'(CordicGain);
    stage_q[0].y <= '0;
    if (z0 > 20'sd102944) begin
      stage_q[0].z <= z0 - 20'sd205887;
      stage_q[0].flip <= 1'b1;
    end else if (z0 < -20'sd102944) begin
      stage_q[0].z <= z0 + 20'sd205887;
      stage_q[0].flip <= 1'b1;
    end else begin
      stage_q[0].z <= z0;
      stage_q[0].flip <= 1'b0;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      stage_q[i+1].flip <= stage_q[i].flip;
      if (!stage_q[i].z[19]) begin
        stage_q[i+1].x <= stage_q[i].x - (stage_q[i].y >>> i);
        stage_q[i+1].y <= stage_q[i].y + (stage_q[i].x >>> i);
        stage_q[i+1].z <= stage_q[i].z - atan_lut(4'(i));
      end else begin
        stage_q[i+1].x <= stage_q[i].x + (stage_q[i].y >>> i);
        stage_q[i+1].y <= stage_q[i].y - (stage_q[i].x >>> i);
        stage_q[i+1].z <= stage_q[i].z + atan_lut(4'(i));
      end
    end
  end

  logic signed [19:0] xr, yr;
  always_comb begin
    xr = (stage_q[CordicSteps].x + 20'sd2) >>> 2;
    yr = (stage_q[CordicSteps].y + 20'sd2) >>> 2;
  end

  always_ff @(posedge clk_i) begin
    cos_o <= stage_q[CordicSteps].flip ? 16'(-xr) : 16'(xr);
    sin_o <= stage_q[CordicSteps].flip ? 16'(-yr) : 16'(yr);
  end

endmodule

// ===== hw/rtl/quaternion_attitude_pd_control.sv =====
// Top level of the quaternion attitude PD controller: configuration registers,
// half-angle CORDICs, quaternion products, PD terms and thrust select.
// Depends on qapd_pkg and qapd_cordic.
//
// Channel   Direction  Handshake               Payload
// command   in         start, busy             in_i   (in_beat_t)
// result    out        done_o strobe           out_o  (out_beat_t)
// config    in         cfg_valid_i/cfg_ready_o cfg_idx_i, cfg_data_i
//
// One beat enters every cycle; its result strobes out on done_o alongside out_o.
// The latency is set by the 18-stage CORDIC pipeline and eight product stages.
// busy is always low: the pipeline has no stall, since results cannot be held.
// Reset clears the valid chain and loads the register reset values.
`timescale 1ns / 1ps
module quaternion_attitude_pd_control
  import qapd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  in_beat_t            in_i,
  output logic                done_o,
  output out_beat_t           out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int Lat = CordicSteps + 2 + 8;

  logic [15:0] att_p_q, att_d_q, yaw_p_q, yaw_d_q, thr_scale_q;
  logic [14:0] pitch_lim_q;
  logic signed [15:0] yaw_set_q;

  assign cfg_ready_o = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_p_q <= 16'd9830;
      att_d_q <= 16'd2867;
      yaw_p_q <= 16'd4096;
      yaw_d_q <= 16'd819;
      thr_scale_q <= 16'd38725;
      pitch_lim_q <= 15'd320;
      yaw_set_q <= -16'sd54;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegAttP: att_p_q <= cfg_data_i;
        RegAttD: att_d_q <= cfg_data_i;
        RegYawP: yaw_p_q <= cfg_data_i;
        RegYawD: yaw_d_q <= cfg_data_i;
        RegThrScale: thr_scale_q <= cfg_data_i;
        RegPitchLim: pitch_lim_q <= cfg_data_i[14:0];
        RegYawSet: yaw_set_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid chain.
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[Lat-2:0], start};
  end

  // Side data delayed alongside the CORDIC.
  localparam int CL = CordicSteps + 2;
  in_beat_t dly_q [CL];
  always_ff @(posedge clk_i) begin
    dly_q[0] <= in_i;
    for (int k = 1; k < CL; k++) dly_q[k] <= dly_q[k-1];
  end

  logic signed [15:0] cy, sy, cp, sp, cr, sr;
  qapd_cordic u_yaw (.clk_i, .angle_i(17'(yaw_set_q)), .cos_o(cy), .sin_o(sy));
  qapd_cordic u_pit (.clk_i, .angle_i(-17'(in_i.pitch_target)), .cos_o(cp), .sin_o(sp));
  qapd_cordic u_rol (.clk_i, .angle_i(-17'(in_i.roll_target)), .cos_o(cr), .sin_o(sr));

  in_beat_t b0;
  assign b0 = dly_q[CL-1];

  // Stage A: pair products Q28.
  logic signed [31:0] cpcr_q, spsr_q, cpsr_q, spcr_q;
  logic signed [15:0] cya_q, sya_q;
  in_beat_t ba_q;
  always_ff @(posedge clk_i) begin
    cpcr_q <= cp * cr;
    spsr_q <= sp * sr;
    cpsr_q <= cp * sr;
    spcr_q <= sp * cr;
    cya_q <= cy;
    sya_q <= sy;
    ba_q <= b0;
  end

  // Stage B: triple products Q42.
  logic signed [47:0] t_q [8];
  in_beat_t bb_q;
  always_ff @(posedge clk_i) begin
    t_q[0] <= cya_q * cpcr_q;
    t_q[1] <= sya_q * spsr_q;
    t_q[2] <= cya_q * cpsr_q;
    t_q[3] <= sya_q * spcr_q;
    t_q[4] <= sya_q * cpsr_q;
    t_q[5] <= cya_q * spcr_q;
    t_q[6] <= sya_q * cpcr_q;
    t_q[7] <= cya_q * spsr_q;
    bb_q <= ba_q;
  end

  // Stage C: desired quaternion, rounded to Q14.
  localparam logic signed [48:0] Half28 = 49'sd134217728;
  logic signed [48:0] sw, sx, sy2, sz;
  always_comb begin
    sw = 49'(t_q[0]) + 49'(t_q[1]) + Half28;
    sx = 49'(t_q[2]) - 49'(t_q[3]) + Half28;
    sy2 = 49'(t_q[4]) + 49'(t_q[5]) + Half28;
    sz = 49'(t_q[6]) - 49'(t_q[7]) + Half28;
  end
  logic signed [20:0] dw_q, dx_q, dy_q, dz_q;
  in_beat_t bc_q;
  always_ff @(posedge clk_i) begin
    dw_q <= 21'(sw >>> 28);
    dx_q <= -21'(sx >>> 28);
    dy_q <= -21'(sy2 >>> 28);
    dz_q <= -21'(sz >>> 28);
    bc_q <= bb_q;
  end

  // Stage D: error cross products.
  logic signed [16:0] bw, bx, by, bz;
  assign bw = 17'(bc_q.quat_w);
  assign bx = 17'(bc_q.quat_x);
  assign by = -17'(bc_q.quat_y);
  assign bz = 17'(bc_q.quat_z);
  logic signed [37:0] m_q [12];
  in_beat_t bd_q;
  always_ff @(posedge clk_i) begin
    m_q[0] <= dw_q * bx;  m_q[1] <= bw * dx_q;
    m_q[2] <= dy_q * bz;  m_q[3] <= dz_q * by;
    m_q[4] <= dw_q * by;  m_q[5] <= bw * dy_q;
    m_q[6] <= dz_q * bx;  m_q[7] <= dx_q * bz;
    m_q[8] <= dw_q * bz;  m_q[9] <= bw * dz_q;
    m_q[10] <= dx_q * by; m_q[11] <= dy_q * bx;
    bd_q <= bc_q;
  end

  // Stage E: error sums rounded to Q14; rates.
  logic signed [39:0] s1, s2, s3;
  always_comb begin
    s1 = 40'(m_q[0]) - 40'(m_q[1]) + 40'(m_q[2]) - 40'(m_q[3]) + 40'sd8192;
    s2 = 40'(m_q[4]) - 40'(m_q[5]) + 40'(m_q[6]) - 40'(m_q[7]) + 40'sd8192;
    s3 = 40'(m_q[8]) - 40'(m_q[9]) + 40'(m_q[10]) - 40'(m_q[11]) + 40'sd8192;
  end
  logic signed [25:0] e1_q, e2_q, e3_q;
  logic signed [36:0] gp_q, gq_q, gr_q;
  in_beat_t be_q;
  always_ff @(posedge clk_i) begin
    e1_q <= 26'(s1 >>> 14);
    e2_q <= 26'(s2 >>> 14);
    e3_q <= 26'(s3 >>> 14);
    gp_q <= bd_q.gyro_x * 37'sd292818;
    gq_q <= bd_q.gyro_y * 37'sd292818;
    gr_q <= bd_q.gyro_z * 37'sd292818;
    be_q <= bd_q;
  end

  // Stage F: rates rounded; P products.
  logic signed [21:0] p_q, q_q, r_q;
  logic signed [43:0] pe1_q, pe2_q, pe3_q;
  in_beat_t bf_q;
  always_ff @(posedge clk_i) begin
    p_q <= 22'((gp_q + 37'sd32768) >>> 16);
    q_q <= 22'((gq_q + 37'sd32768) >>> 16);
    r_q <= 22'((gr_q + 37'sd32768) >>> 16);
    pe1_q <= $signed({1'b0, att_p_q}) * e1_q;
    pe2_q <= $signed({1'b0, att_p_q}) * e2_q;
    pe3_q <= $signed({1'b0, yaw_p_q}) * e3_q;
    bf_q <= be_q;
  end

  // Stage G: D products, throttle scaling and manual-mode compare.
  logic signed [39:0] dp_q, dq_q, dr_q;
  logic signed [43:0] pe1g_q, pe2g_q, pe3g_q;
  logic [23:0] thr_q;
  logic manual_q;
  logic [15:0] pthr_q;
  always_ff @(posedge clk_i) begin
    dp_q <= $signed({1'b0, att_d_q}) * p_q;
    dq_q <= $signed({1'b0, att_d_q}) * q_q;
    dr_q <= $signed({1'b0, yaw_d_q}) * r_q;
    pe1g_q <= pe1_q;
    pe2g_q <= pe2_q;
    pe3g_q <= pe3_q;
    thr_q <= bf_q.radio_throttle * thr_scale_q;
    manual_q <= bf_q.radio_pitch < $signed({1'b0, pitch_lim_q});
    pthr_q <= bf_q.position_thrust;
  end

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return -16'sh8000;
    return 16'(v);
  endfunction

  // Stage H: PD sums, round, saturate; thrust select.
  logic signed [47:0] ur, up, uy;
  logic [24:0] tm;
  always_comb begin
    ur = -48'(pe1g_q) - (48'(dp_q) <<< 2) + 48'sd32768;
    up = -48'(pe2g_q) + (48'(dq_q) <<< 2) + 48'sd32768;
    uy = -48'(pe3g_q) - (48'(dr_q) <<< 2) + 48'sd32768;
    tm = (25'(thr_q) + 25'd2048) >> 12;
  end
  always_ff @(posedge clk_i) begin
    out_o.roll_command <= sat16(ur >>> 16);
    out_o.pitch_command <= sat16(up >>> 16);
    out_o.yaw_command <= sat16(uy >>> 16);
    out_o.thrust_command <= !manual_q ? pthr_q : (tm > 25'd65535 ? 16'hffff : 16'(tm));
  end

  assign done_o = vld_q[Lat-1];

endmodule

// ===== hw/rtl/qapd_checker.sv =====
// Port checker for the quaternion attitude PD controller, bound to the top.
// Depends on qapd_pkg.
`timescale 1ns / 1ps
module qapd_checker
  import qapd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic cfg_ready_o
);

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config not ready");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##26 done_o) else $error("result missing");
  a_nosp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> ##26 !done_o) else $error("spurious result");

endmodule

bind quaternion_attitude_pd_control qapd_checker u_chk (.*);
